// File: rtl/lspc_pkg.sv
// ----------------------------------------------------------------------------
// lspc_pkg
// Shared types, constants and helpers for the log page counter parser.
// ----------------------------------------------------------------------------
package lspc_pkg;

  localparam int NUM_COUNTERS   = 7;
  localparam int MAX_PAGE_BYTES = 256;
  localparam int MIN_PAGE_BYTES = 8;
  localparam int MAX_ASCII_LEN  = 16;
  localparam int MAX_BINARY_LEN = 8;
  localparam int LAST_CODE      = 6;

  localparam int IDX_W    = 3;
  localparam int ADDR_W   = IDX_W + 1;
  localparam int VALUE_W  = 64;
  localparam int OFF_W    = $clog2(MAX_PAGE_BYTES + 1);
  localparam int LEFT_W   = $clog2(MAX_ASCII_LEN + 1);
  localparam int STATUS_W = 3;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_CODE_HI,
    PH_CODE_LO,
    PH_CONTROL,
    PH_LENGTH,
    PH_VALUE
  } phase_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_TOO_LONG  = 3'd2,
    ST_BAD_HEX   = 3'd3,
    ST_TRUNCATED = 3'd4
  } status_t;

  // Counter store write port
  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
    logic [VALUE_W-1:0] data;
  } lspc_wr_t;

  // Finished page handed to the result side
  typedef struct packed {
    logic    start;
    logic    bank;
    status_t status;
  } lspc_job_t;

  // Decode one ASCII hex digit: bit 4 set when the byte is a digit
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(b - 8'h61 + 8'd10)};
    end else if (b inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(b - 8'h41 + 8'd10)};
    end
    return r;
  endfunction

endpackage

// File: rtl/scsi_log_page_counter_parser.sv
// ----------------------------------------------------------------------------
// scsi_log_page_counter_parser
// Parses a log sense error-counter page and reports its counters.
// ----------------------------------------------------------------------------
// Input: one page byte per cycle; ready falls only on a last byte while the
// previous page's results are still being sent.
// Output: seven counter transactions per page, the first in the cycle after the
// last byte via the registered store read, then one per cycle while m_tready is high.
// Reset (rst, synchronous): parser and result side return to idle at once.
module scsi_log_page_counter_parser
  import lspc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] page_byte
  input  logic        s_tlast,   // page_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [2:0] counter_index, [66:3] counter_value,
                                 // [69:67] parse_status, [71:70] zero
  output logic        m_tlast    // run_last
);

  logic                   acc;
  logic                   free;
  lspc_wr_t               wr;
  lspc_job_t              job;
  logic [(1<<ADDR_W)-1:0] valid;
  logic [ADDR_W-1:0]      raddr;
  logic [VALUE_W-1:0]     rdata;

  // Stall a closing byte until the result side can take the page
  assign s_tready = !s_tlast || free;
  assign acc      = s_tvalid && s_tready;

  lspc_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .acc       (acc),
    .page_byte (s_tdata),
    .page_end  (s_tlast),
    .wr        (wr),
    .job       (job),
    .valid     (valid)
  );

  lspc_ram #(
    .DATA_W (VALUE_W),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (raddr),
    .rdata (rdata)
  );

  lspc_emitter u_emitter (
    .clk      (clk),
    .rst      (rst),
    .job      (job),
    .wr       (wr),
    .valid    (valid),
    .rdata    (rdata),
    .raddr    (raddr),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// File: rtl/lspc_ram.sv
// ----------------------------------------------------------------------------
// lspc_ram
// Simple dual-port RAM, registered read, write-first on collision.
// ----------------------------------------------------------------------------
module lspc_ram #(
  parameter int DATA_W = 64,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [(1<<ADDR_W)];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, forward a same-cycle write
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/lspc_parser.sv
// ----------------------------------------------------------------------------
// lspc_parser
// Byte walker: page header, parameter records and value accumulation.
// Writes finished counters into the active bank of the counter store.
// ----------------------------------------------------------------------------
module lspc_parser
  import lspc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   acc,
  input  logic [7:0]             page_byte,
  input  logic                   page_end,
  output lspc_wr_t               wr,
  output lspc_job_t              job,
  output logic [(1<<ADDR_W)-1:0] valid
);

  logic [OFF_W-1:0]   byte_offset, byte_offset_next;
  logic [15:0]        header_length, header_length_next;
  phase_t             phase, phase_next;
  logic [IDX_W-1:0]   code, code_next;
  logic               code_ok, code_ok_next;
  logic               ascii, ascii_next;
  logic [LEFT_W-1:0]  left, left_next;
  logic [VALUE_W-1:0] accum, accum_next;
  logic               done, done_next;
  status_t            err, err_next;
  logic               bank, bank_next;
  logic [(1<<ADDR_W)-1:0] valid_next;
  logic [4:0]         hex;
  logic [15:0]        rec_off;

  assign hex     = hex_digit(page_byte);
  assign rec_off = 16'(byte_offset) - 16'd4;

  // Walk one byte
  always_comb begin
    byte_offset_next   = byte_offset;
    header_length_next = header_length;
    phase_next         = phase;
    code_next          = code;
    code_ok_next       = code_ok;
    ascii_next         = ascii;
    left_next          = left;
    accum_next         = accum;
    done_next          = done;
    err_next           = err;
    bank_next          = bank;
    valid_next         = valid;
    wr                 = '0;
    job                = '0;
    job.status         = ST_OK;

    if (acc && (byte_offset < OFF_W'(MAX_PAGE_BYTES))) begin
      byte_offset_next = byte_offset + OFF_W'(1);
      if (!done) begin
        case (phase)
          PH_HEADER: begin
            if (byte_offset == OFF_W'(2)) begin
              header_length_next = {page_byte, 8'h00};
            end else if (byte_offset == OFF_W'(3)) begin
              header_length_next = {header_length[15:8], page_byte};
              phase_next         = PH_CODE_HI;
            end
          end
          PH_CODE_HI: begin
            if (rec_off >= header_length) begin
              done_next = 1'b1;
            end else begin
              code_ok_next = (page_byte == 8'h00);
              phase_next   = PH_CODE_LO;
            end
          end
          PH_CODE_LO: begin
            code_ok_next = code_ok && (page_byte < 8'(NUM_COUNTERS))
                           && (page_byte <= 8'(LAST_CODE));
            code_next    = page_byte[IDX_W-1:0];
            phase_next   = PH_CONTROL;
          end
          PH_CONTROL: begin
            ascii_next = page_byte[0] && !page_byte[1];
            phase_next = PH_LENGTH;
          end
          PH_LENGTH: begin
            if ((page_byte == 8'h00) || !code_ok) begin
              done_next = 1'b1;
            end else if (ascii ? (page_byte > 8'(MAX_ASCII_LEN))
                               : (page_byte > 8'(MAX_BINARY_LEN))) begin
              err_next  = ST_TOO_LONG;
              done_next = 1'b1;
            end else begin
              left_next  = page_byte[LEFT_W-1:0];
              accum_next = '0;
              phase_next = PH_VALUE;
            end
          end
          PH_VALUE: begin
            if (ascii && !hex[4]) begin
              err_next  = ST_BAD_HEX;
              done_next = 1'b1;
            end else begin
              if (ascii) begin
                accum_next = {accum[VALUE_W-5:0], hex[3:0]};
              end else begin
                accum_next = {accum[VALUE_W-9:0], page_byte};
              end
              left_next = left - LEFT_W'(1);
              if (left == LEFT_W'(1)) begin
                wr.en   = 1'b1;
                wr.addr = {bank, code};
                wr.data = accum_next;
                valid_next[{bank, code}] = 1'b1;
                if ((code == IDX_W'(LAST_CODE)) || (code == IDX_W'(NUM_COUNTERS - 1))) begin
                  done_next = 1'b1;
                end else begin
                  phase_next = PH_CODE_HI;
                end
              end
            end
          end
          default: begin
            done_next = 1'b1;
          end
        endcase
      end
    end

    // Close the page: report status, swap banks, clear state
    if (acc && page_end) begin
      job.start = 1'b1;
      job.bank  = bank;
      if (byte_offset_next < OFF_W'(MIN_PAGE_BYTES)) begin
        job.status = ST_SHORT;
      end else if (err_next != ST_OK) begin
        job.status = err_next;
      end else if (!done_next && (phase_next inside {PH_CODE_LO, PH_CONTROL,
                                                      PH_LENGTH, PH_VALUE})) begin
        job.status = ST_TRUNCATED;
      end
      bank_next          = !bank;
      byte_offset_next   = '0;
      header_length_next = '0;
      phase_next         = PH_HEADER;
      code_next          = '0;
      code_ok_next       = 1'b0;
      ascii_next         = 1'b0;
      left_next          = '0;
      done_next          = 1'b0;
      err_next           = ST_OK;
      for (int i = 0; i < (1 << IDX_W); i++) begin
        valid_next[{!bank, IDX_W'(i)}] = 1'b0;
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset   <= '0;
      header_length <= '0;
      phase         <= PH_HEADER;
      code          <= '0;
      code_ok       <= 1'b0;
      ascii         <= 1'b0;
      left          <= '0;
      done          <= 1'b0;
      err           <= ST_OK;
      bank          <= 1'b0;
      valid         <= '0;
    end else begin
      byte_offset   <= byte_offset_next;
      header_length <= header_length_next;
      phase         <= phase_next;
      code          <= code_next;
      code_ok       <= code_ok_next;
      ascii         <= ascii_next;
      left          <= left_next;
      done          <= done_next;
      err           <= err_next;
      bank          <= bank_next;
      valid         <= valid_next;
    end
  end

  // Value accumulator
  always_ff @(posedge clk) begin
    accum <= accum_next;
  end

endmodule

// File: rtl/lspc_emitter.sv
// ----------------------------------------------------------------------------
// lspc_emitter
// Result side: sweeps the finished bank of the counter store and presents
// one counter per transaction.
// ----------------------------------------------------------------------------
module lspc_emitter
  import lspc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  lspc_job_t              job,
  input  lspc_wr_t               wr,
  input  logic [(1<<ADDR_W)-1:0] valid,
  input  logic [VALUE_W-1:0]     rdata,
  output logic [ADDR_W-1:0]      raddr,
  output logic                   free,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [71:0]            m_tdata,
  output logic                   m_tlast
);

  logic [IDX_W-1:0] idx, idx_next;
  logic             ebank, ebank_next;
  status_t          status, status_next;
  logic             m_tvalid_next;
  logic             rd_valid;
  logic             last;
  logic [VALUE_W-1:0] value;

  assign last  = (idx == IDX_W'(NUM_COUNTERS - 1));
  assign free  = !m_tvalid || (m_tready && last);
  assign raddr = {ebank_next, idx_next};

  // Select the entry to present next
  always_comb begin
    idx_next      = idx;
    ebank_next    = ebank;
    status_next   = status;
    m_tvalid_next = m_tvalid;
    if (job.start) begin
      idx_next      = '0;
      ebank_next    = job.bank;
      status_next   = job.status;
      m_tvalid_next = 1'b1;
    end else if (m_tvalid && m_tready) begin
      if (last) begin
        m_tvalid_next = 1'b0;
      end else begin
        idx_next = idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= '0;
      ebank    <= 1'b0;
      status   <= ST_OK;
    end else begin
      m_tvalid <= m_tvalid_next;
      idx      <= idx_next;
      ebank    <= ebank_next;
      status   <= status_next;
    end
  end

  // Entry written this page, aligned with the store read
  always_ff @(posedge clk) begin
    rd_valid <= valid[raddr] || (wr.en && (wr.addr == raddr));
  end

  // Drive the result transaction
  assign value   = ((status == ST_SHORT) || !rd_valid) ? '0 : rdata;
  assign m_tdata = {2'b00, status, value, idx};
  assign m_tlast = last;

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the log page counter parser against a cycle-free predictor. Pages are
// streamed byte by byte: first a short list of hand-built pages (short page,
// extreme values, every hex digit class, long values, bad digits, truncation,
// early ends), then random pages, mostly well-formed records with random
// content and some noise, plus one page past the size limit. Each counter
// transaction is compared field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module tb;
  import lspc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_TICKS = 16;
  localparam int RAND_BYTES   = 48;
  localparam int IDLE_PCT     = 27;
  localparam int BIG_PAGE_LEN = 260;

  // One hand-built page; bytes read from the top of the literal down
  typedef struct packed {
    int unsigned  n;
    logic [191:0] bytes;
    logic         typed;
    status_t      status;
  } dir_page_t;

  // One predicted counter transaction
  typedef struct {
    logic [2:0]  idx;
    logic [63:0] value;
    status_t     status;
    logic        last;
  } counter_rec_t;

  localparam dir_page_t DIRECTED_PAGES [11] = '{
    // single byte page
    '{32'd1, 192'hFF, 1'b1, ST_SHORT},
    // seven bytes, record cut short, still a short page
    '{32'd7, 192'h00_00_00_03_00_00_02, 1'b1, ST_SHORT},
    // binary all-ones in counter 0, then counter 6 ends the walk
    '{32'd21, 192'h00_00_00_11_00_00_00_08_FF_FF_FF_FF_FF_FF_FF_FF_00_06_02_01_00,
      1'b0, ST_OK},
    // sixteen ASCII digits, every digit class, ending on a record boundary
    '{32'd24, 192'h00_00_00_14_00_01_01_10_30_31_32_33_34_35_36_37_38_39_61_62_63_44_45_46,
      1'b0, ST_OK},
    // ASCII value one digit too long
    '{32'd8, 192'h00_00_00_08_00_02_01_11, 1'b1, ST_TOO_LONG},
    // LP with LBIN is binary: nine bytes too long
    '{32'd8, 192'h00_00_00_08_00_03_03_09, 1'b1, ST_TOO_LONG},
    // space inside an ASCII value
    '{32'd10, 192'h00_00_00_06_00_00_01_02_31_20, 1'b1, ST_BAD_HEX},
    // page ends inside a binary value
    '{32'd10, 192'h00_00_00_10_00_01_00_04_AA_BB, 1'b1, ST_TRUNCATED},
    // zero length ends the walk, trailing bytes ignored
    '{32'd12, 192'h00_00_00_0C_00_02_00_00_55_66_77_88, 1'b1, ST_OK},
    // largest page length and largest code
    '{32'd12, 192'h00_00_FF_FF_FF_FF_00_04_12_34_56_78, 1'b1, ST_OK},
    // page length zero: no record is started
    '{32'd9, 192'h00_00_00_00_00_01_00_01_07, 1'b1, ST_OK}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic        m_tlast;

  // Predictor state
  logic [OFF_W-1:0] pg_off;
  logic [15:0]      pg_len;
  phase_t           pg_phase;
  logic [15:0]      rec_code;
  logic             rec_ascii;
  logic [7:0]       val_left;
  logic [63:0]      val_acc;
  logic [63:0]      counts [NUM_COUNTERS];
  logic             walk_done;
  status_t          walk_err;

  counter_rec_t counter_q [$];
  logic         typed_on = 1'b0;
  status_t      typed_status = ST_OK;
  logic         tx_idle_on = 1'b1;
  logic         rx_stall_on = 1'b1;
  int           fail_count = 0;
  int           cycle_count = 0;

  scsi_log_page_counter_parser u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // Clear the predictor for a new page
  function automatic void page_clear();
    pg_off    = '0;
    pg_len    = '0;
    pg_phase  = PH_HEADER;
    rec_code  = '0;
    rec_ascii = 1'b0;
    val_left  = '0;
    val_acc   = '0;
    walk_done = 1'b0;
    walk_err  = ST_OK;
    for (int k = 0; k < NUM_COUNTERS; k++) counts[k] = '0;
  endfunction

  // Hex digit value, or -1 for any other byte
  function automatic int digit_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  // Advance the record walk by one byte
  function automatic void walk_byte(logic [OFF_W-1:0] off, logic [7:0] b);
    int d;
    if (walk_done) return;
    case (pg_phase)
      PH_HEADER: begin
        if (off == 2) begin
          pg_len = {b, 8'h00};
        end else if (off == 3) begin
          pg_len[7:0] = b;
          pg_phase    = PH_CODE_HI;
        end
      end
      PH_CODE_HI: begin
        if (int'(off) - 4 >= int'(pg_len)) begin
          walk_done = 1'b1;
        end else begin
          rec_code = {b, 8'h00};
          pg_phase = PH_CODE_LO;
        end
      end
      PH_CODE_LO: begin
        rec_code[7:0] = b;
        pg_phase      = PH_CONTROL;
      end
      PH_CONTROL: begin
        rec_ascii = b[0] && !b[1];
        pg_phase  = PH_LENGTH;
      end
      PH_LENGTH: begin
        if (b == 0 || rec_code >= NUM_COUNTERS || rec_code > LAST_CODE) begin
          walk_done = 1'b1;
        end else if (rec_ascii ? (b > MAX_ASCII_LEN) : (b > MAX_BINARY_LEN)) begin
          walk_err  = ST_TOO_LONG;
          walk_done = 1'b1;
        end else begin
          val_left = b;
          val_acc  = '0;
          pg_phase = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (rec_ascii) begin
          d = digit_value(b);
          if (d < 0) begin
            walk_err  = ST_BAD_HEX;
            walk_done = 1'b1;
            return;
          end
          val_acc = {val_acc[59:0], 4'(d)};
        end else begin
          val_acc = {val_acc[55:0], b};
        end
        val_left--;
        if (val_left == 0) begin
          if (rec_code < NUM_COUNTERS) counts[rec_code[2:0]] = val_acc;
          if (rec_code == LAST_CODE || rec_code == NUM_COUNTERS - 1) walk_done = 1'b1;
          else pg_phase = PH_CODE_HI;
        end
      end
      default: walk_done = 1'b1;
    endcase
  endfunction

  // Take one accepted byte; on the last byte queue the counter transactions
  function automatic void predict_counters(logic [7:0] b, logic last);
    status_t      st;
    counter_rec_t rec;
    if (pg_off < MAX_PAGE_BYTES) begin
      walk_byte(pg_off, b);
      pg_off++;
    end
    if (!last) return;
    if (pg_off < MIN_PAGE_BYTES) st = ST_SHORT;
    else if (walk_err != ST_OK) st = walk_err;
    else if (!walk_done && pg_phase inside {PH_CODE_LO, PH_CONTROL, PH_LENGTH, PH_VALUE})
      st = ST_TRUNCATED;
    else st = ST_OK;
    for (int k = 0; k < NUM_COUNTERS; k++) begin
      rec.idx    = 3'(k);
      rec.value  = (st == ST_SHORT) ? 64'd0 : counts[k];
      rec.status = typed_on ? typed_status : st;
      rec.last   = (k == NUM_COUNTERS - 1);
      counter_q.push_back(rec);
    end
    page_clear();
  endfunction

  // Random hex digit in either case
  function automatic logic [7:0] hex_char(int unsigned d);
    if (d < 10) return 8'("0" + d);
    if ($urandom_range(1)) return 8'("a" + d - 10);
    return 8'("A" + d - 10);
  endfunction

  // Monitor both sides at the rising edge: predict first, then check
  always @(posedge clk) begin
    counter_rec_t want;
    if (rst) begin
      page_clear();
    end else begin
      if (s_tvalid && s_tready) predict_counters(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (counter_q.size() == 0) begin
          $error("unexpected counter transaction: index %0d", m_tdata[2:0]);
          fail_count++;
        end else begin
          want = counter_q.pop_front();
          if (m_tdata[2:0] !== want.idx) begin
            $error("counter_index: expected %0d, got %0d", want.idx, m_tdata[2:0]);
            fail_count++;
          end
          if (m_tdata[66:3] !== want.value) begin
            $error("counter_value: expected %h, got %h", want.value, m_tdata[66:3]);
            fail_count++;
          end
          if (m_tdata[69:67] !== want.status) begin
            $error("parse_status: expected %0d, got %0d", want.status, m_tdata[69:67]);
            fail_count++;
          end
          if (m_tlast !== want.last) begin
            $error("run_last: expected %0d, got %0d", want.last, m_tlast);
            fail_count++;
          end
        end
      end
    end
  end

  // Hold off the result side at random
  always @(negedge clk) begin
    m_tready <= rx_stall_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Offer one byte from a falling edge and hold it until accepted
  task automatic send_byte(logic [7:0] b, logic last);
    while (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = b;
    s_tlast  = last;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic send_page(logic [7:0] pg [$]);
    foreach (pg[i]) send_byte(pg[i], i == pg.size() - 1);
  endtask

  // Pause the sender until every queued counter transaction has arrived
  task automatic wait_drain();
    s_tvalid = 1'b0;
    while (counter_q.size() != 0) @(negedge clk);
  endtask

  // Build a random page: mostly well-formed records, some plain noise
  task automatic build_page(ref logic [7:0] pg [$]);
    int unsigned nrec, code, ctl, len, r, cut;
    logic [15:0] hdr;
    logic [7:0]  body [$];
    logic        ascii;
    pg.delete();
    if ($urandom_range(99) >= 80) begin
      repeat ($urandom_range(1, 40)) pg.push_back(8'($urandom_range(255)));
      return;
    end
    nrec = $urandom_range(0, 7);
    repeat (nrec) begin
      code  = ($urandom_range(99) < 5) ? $urandom_range(7, 16'hFFFF) : $urandom_range(0, 6);
      ctl   = $urandom_range(255);
      ascii = ctl[0] && !ctl[1];
      r     = $urandom_range(99);
      if (r < 4) len = 0;
      else if (r < 8) len = ascii ? $urandom_range(17, 255) : $urandom_range(9, 255);
      else len = ascii ? $urandom_range(1, 16) : $urandom_range(1, 8);
      body.push_back(code[15:8]);
      body.push_back(code[7:0]);
      body.push_back(ctl[7:0]);
      body.push_back(len[7:0]);
      if (len <= MAX_ASCII_LEN) begin
        for (int i = 0; i < len; i++) begin
          if (!ascii) body.push_back(8'($urandom_range(255)));
          else if ($urandom_range(99) < 3) body.push_back(8'($urandom_range(255)));
          else body.push_back(hex_char($urandom_range(15)));
        end
      end
    end
    hdr = 16'(body.size());
    if ($urandom_range(99) < 15) hdr = 16'($urandom_range(16'hFFFF));
    pg.push_back(8'($urandom_range(255)));
    pg.push_back(8'($urandom_range(255)));
    pg.push_back(hdr[15:8]);
    pg.push_back(hdr[7:0]);
    foreach (body[i]) pg.push_back(body[i]);
    // drop the tail or pad the page now and then
    if ($urandom_range(99) < 15 && body.size() > 0) begin
      cut = $urandom_range(1, body.size());
      repeat (cut) void'(pg.pop_back());
    end else if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 6)) pg.push_back(8'($urandom_range(255)));
    end
  endtask

  initial begin
    logic [7:0]  pg [$];
    int unsigned n;
    int          rand_bytes;
    int          page_no;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Hand-built pages
    foreach (DIRECTED_PAGES[p]) begin
      typed_on     = DIRECTED_PAGES[p].typed;
      typed_status = DIRECTED_PAGES[p].status;
      n            = DIRECTED_PAGES[p].n;
      for (int i = 0; i < n; i++)
        send_byte(DIRECTED_PAGES[p].bytes[(n - 1 - i) * 8 +: 8], i == n - 1);
    end
    typed_on = 1'b0;

    // Random pages with random idling on both sides
    rand_bytes = 0;
    page_no    = 0;
    while (rand_bytes < RAND_BYTES) begin
      if (page_no == 1) wait_drain();
      build_page(pg);
      send_page(pg);
      rand_bytes += pg.size();
      page_no++;
    end

    // One page past the size limit, binary records throughout, with no
    // idling on either side
    wait_drain();
    tx_idle_on  = 1'b0;
    rx_stall_on = 1'b0;
    pg = {8'h03, 8'h00, 8'hFF, 8'hFF};
    while (pg.size() < BIG_PAGE_LEN) begin
      pg.push_back(8'h00);
      pg.push_back(8'($urandom_range(0, 5)));
      pg.push_back(8'h02);
      pg.push_back(8'd8);
      repeat (8) pg.push_back(8'($urandom_range(255)));
    end
    send_page(pg);

    wait_drain();
    repeat (SETTLE_TICKS) @(negedge clk);
    if (counter_q.size() != 0) begin
      $error("%0d counter transactions never arrived", counter_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
